// ----- rtl/adcm9_pkg.sv -----
package adcm9_pkg;

	localparam int CHANNELS = 4;
	localparam int SLOTS    = CHANNELS * 9;
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int SMP_W    = 12;
	localparam int CH_W     = 2;
	localparam int IDX_W    = 4;
	localparam int STEP_W   = 5;
	localparam int NSTEPS   = 19;
	localparam int DVD_W    = 22;
	localparam int DVS_W    = 13;
	localparam int TEMP_W   = 23;
	localparam int VDD_W    = 21;

	localparam logic [CH_W-1:0] TEMP_CH = CH_W'(2 % CHANNELS);
	localparam logic [CH_W-1:0] VREF_CH = CH_W'(3 % CHANNELS);

	localparam logic [1:0] REG_CAL30  = 2'd0;
	localparam logic [1:0] REG_CAL110 = 2'd1;
	localparam logic [1:0] REG_VREF   = 2'd2;

	localparam logic OP_STORE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic                store_wr;
		logic                rd_en;
		logic [CH_W-1:0]     rd_ch;
		logic [IDX_W-1:0]    rd_idx;
		logic                ld_en;
		logic [IDX_W-1:0]    ld_idx;
		logic                xchg_en;
		logic [STEP_W-1:0]   xchg_step;
		logic                med_cap;
		logic [1:0]          med_sel;
		logic                prod_en;
		logic                div_start;
		logic                out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} sts_t;

	// median-of-9 exchange network, {a, b}
	function automatic logic [7:0] xchg_pair(input logic [STEP_W-1:0] s);
		logic [7:0] p;
		unique case (s)
			5'd0:    p = {4'd1, 4'd2};
			5'd1:    p = {4'd4, 4'd5};
			5'd2:    p = {4'd7, 4'd8};
			5'd3:    p = {4'd0, 4'd1};
			5'd4:    p = {4'd3, 4'd4};
			5'd5:    p = {4'd6, 4'd7};
			5'd6:    p = {4'd1, 4'd2};
			5'd7:    p = {4'd4, 4'd5};
			5'd8:    p = {4'd7, 4'd8};
			5'd9:    p = {4'd0, 4'd3};
			5'd10:   p = {4'd5, 4'd8};
			5'd11:   p = {4'd4, 4'd7};
			5'd12:   p = {4'd3, 4'd6};
			5'd13:   p = {4'd1, 4'd4};
			5'd14:   p = {4'd2, 4'd5};
			5'd15:   p = {4'd4, 4'd7};
			5'd16:   p = {4'd4, 4'd2};
			5'd17:   p = {4'd6, 4'd4};
			5'd18:   p = {4'd4, 4'd2};
			default: p = {4'd4, 4'd4};
		endcase
		return p;
	endfunction

endpackage

// ----- rtl/adc_median9_calibrated_readout.sv -----
// store transaction: accepted while idle, no result
// read transaction: 3 passes of (9 store reads + 19 exchange steps + 1 capture) on the
// one sorting unit, then the product step, the divider start and the wait on the bit-serial
// dividers, then the output load; input is ready again once the result has been loaded
// one read in flight at a time; a finished result waits in the output register
// arst_n clears control and slot valid bits (store reads as zero) and sets calibration defaults
module adc_median9_calibrated_readout (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 op,
	input  logic [adcm9_pkg::SMP_W-1:0]          sample,
	input  logic [adcm9_pkg::CH_W-1:0]           channel,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [adcm9_pkg::SMP_W-1:0]          median,
	output logic signed [adcm9_pkg::TEMP_W-1:0]  temperature_tenths,
	output logic [adcm9_pkg::VDD_W-1:0]          vdd_hundredths,
	output logic [1:0]                           divide_fault,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_index,
	input  logic [adcm9_pkg::SMP_W-1:0]          cfg_wdata
);
	adcm9_pkg::cmd_t cmd;
	adcm9_pkg::sts_t sts;

	adcm9_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.channel  (channel),
		.sts      (sts),
		.cmd      (cmd)
	);

	adcm9_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.sample             (sample),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.median             (median),
		.temperature_tenths (temperature_tenths),
		.vdd_hundredths     (vdd_hundredths),
		.divide_fault       (divide_fault)
	);

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == adcm9_pkg::OP_READ |=> !in_ready)
		else $error("read transaction did not block input");

	a_temp_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_fault[0] |-> temperature_tenths == '0)
		else $error("temperature not zero on divisor fault");

	a_vdd_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_fault[1] |-> vdd_hundredths == '0)
		else $error("vdd not zero on reference fault");
endmodule

// ----- rtl/adcm9_div.sv -----
module adcm9_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [adcm9_pkg::DVD_W-1:0]     dividend,
	input  logic [adcm9_pkg::DVS_W-1:0]     divisor,
	output logic                            done,
	output logic [adcm9_pkg::DVD_W-1:0]     quotient
);
	localparam int CNT_W = $clog2(adcm9_pkg::DVD_W + 1);

	logic [adcm9_pkg::DVS_W-1:0] rem_q;
	logic [adcm9_pkg::DVD_W-1:0] quo_q;
	logic [adcm9_pkg::DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [adcm9_pkg::DVS_W:0]   shifted;
	logic [adcm9_pkg::DVS_W:0]   trial;

	// restoring division, one quotient bit per cycle
	assign shifted = {rem_q, quo_q[adcm9_pkg::DVD_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(adcm9_pkg::DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[adcm9_pkg::DVS_W]) begin
				rem_q <= trial[adcm9_pkg::DVS_W-1:0];
				quo_q <= {quo_q[adcm9_pkg::DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[adcm9_pkg::DVS_W-1:0];
				quo_q <= {quo_q[adcm9_pkg::DVD_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ----- rtl/adcm9_ctrl.sv -----
module adcm9_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [adcm9_pkg::CH_W-1:0]    channel,
	input  adcm9_pkg::sts_t               sts,
	output adcm9_pkg::cmd_t               cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_SORT = 3'd2;
	localparam logic [2:0] S_CAP  = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_WAIT = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [2:0]                     state_q;
	logic [adcm9_pkg::STEP_W-1:0]   cnt_q;
	logic [1:0]                     pass_q;
	logic [adcm9_pkg::CH_W-1:0]     chan_q;
	logic                           accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pass_q  <= '0;
			chan_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && op == adcm9_pkg::OP_READ) begin
						chan_q  <= adcm9_pkg::CH_W'(channel % adcm9_pkg::CHANNELS);
						pass_q  <= '0;
						cnt_q   <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (cnt_q == 5'd9) begin
						cnt_q   <= '0;
						state_q <= S_SORT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SORT: begin
					if (cnt_q == adcm9_pkg::STEP_W'(adcm9_pkg::NSTEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_CAP;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_CAP: begin
					if (pass_q == 2'd2) begin
						state_q <= S_MUL;
					end else begin
						pass_q  <= pass_q + 1'b1;
						state_q <= S_LOAD;
					end
				end
				S_MUL:  state_q <= S_DIV;
				S_DIV:  state_q <= S_WAIT;
				S_WAIT: if (sts.div_done) state_q <= S_OUT;
				S_OUT:  if (sts.out_free) state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.store_wr  = accept && op == adcm9_pkg::OP_STORE;
		cmd.rd_idx    = cnt_q[adcm9_pkg::IDX_W-1:0];
		cmd.ld_idx    = adcm9_pkg::IDX_W'(cnt_q - 1'b1);
		cmd.xchg_step = cnt_q;
		cmd.med_sel   = pass_q;
		unique case (pass_q)
			2'd1:    cmd.rd_ch = adcm9_pkg::TEMP_CH;
			2'd2:    cmd.rd_ch = adcm9_pkg::VREF_CH;
			default: cmd.rd_ch = chan_q;
		endcase
		cmd.rd_en     = (state_q == S_LOAD) && cnt_q != 5'd9;
		cmd.ld_en     = (state_q == S_LOAD) && cnt_q != 5'd0;
		cmd.xchg_en   = (state_q == S_SORT);
		cmd.med_cap   = (state_q == S_CAP);
		cmd.prod_en   = (state_q == S_MUL);
		cmd.div_start = (state_q == S_DIV);
		cmd.out_load  = (state_q == S_OUT) && sts.out_free;
	end
endmodule

// ----- rtl/adcm9_dp.sv -----
module adcm9_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  adcm9_pkg::cmd_t                      cmd,
	output adcm9_pkg::sts_t                      sts,
	input  logic [adcm9_pkg::SMP_W-1:0]          sample,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_index,
	input  logic [adcm9_pkg::SMP_W-1:0]          cfg_wdata,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [adcm9_pkg::SMP_W-1:0]          median,
	output logic signed [adcm9_pkg::TEMP_W-1:0]  temperature_tenths,
	output logic [adcm9_pkg::VDD_W-1:0]          vdd_hundredths,
	output logic [1:0]                           divide_fault
);
	localparam int SW = adcm9_pkg::SMP_W;

	logic [SW-1:0]                    mem [adcm9_pkg::SLOTS];
	logic [adcm9_pkg::SLOTS-1:0]      vld_q;
	logic [adcm9_pkg::SLOT_W-1:0]     wslot_q;
	logic [adcm9_pkg::SLOT_W-1:0]     raddr;
	logic [SW-1:0]                    rd_q;
	logic [SW-1:0]                    v_q [9];
	logic [SW-1:0]                    med_q [3];
	logic [SW-1:0]                    cal30_q, cal110_q, vref_q;
	logic [7:0]                       pair;
	logic [adcm9_pkg::IDX_W-1:0]      ia, ib;
	logic [SW-1:0]                    va, vb;
	logic signed [adcm9_pkg::TEMP_W-1:0] num_q;
	logic signed [adcm9_pkg::DVS_W-1:0]  den_q;
	logic [adcm9_pkg::VDD_W-1:0]      vnum_q;
	logic signed [adcm9_pkg::DVS_W-1:0]  diff;
	logic signed [adcm9_pkg::DVS_W-1:0]  den;
	logic [adcm9_pkg::TEMP_W-1:0]     num_mag;
	logic [adcm9_pkg::DVS_W-1:0]      den_mag;
	logic                             tdone, vdone;
	logic [adcm9_pkg::DVD_W-1:0]      tquo, vquo;
	logic signed [adcm9_pkg::TEMP_W-1:0] tsigned;
	logic                             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal30_q  <= SW'(1700);
			cal110_q <= SW'(1300);
			vref_q   <= SW'(1520);
		end else if (cfg_we) begin
			unique case (cfg_index)
				adcm9_pkg::REG_CAL30:  cal30_q  <= cfg_wdata;
				adcm9_pkg::REG_CAL110: cal110_q <= cfg_wdata;
				adcm9_pkg::REG_VREF:   vref_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sample store, never-written slots read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			wslot_q <= '0;
		end else if (cmd.store_wr) begin
			vld_q[wslot_q] <= 1'b1;
			wslot_q <= (wslot_q == adcm9_pkg::SLOT_W'(adcm9_pkg::SLOTS - 1)) ?
				'0 : wslot_q + 1'b1;
		end
	end

	assign raddr = adcm9_pkg::SLOT_W'(cmd.rd_ch)
		+ adcm9_pkg::SLOT_W'(cmd.rd_idx) * adcm9_pkg::SLOT_W'(adcm9_pkg::CHANNELS);

	always_ff @(posedge clk) begin
		if (cmd.store_wr) mem[wslot_q] <= sample;
		if (cmd.rd_en) rd_q <= vld_q[raddr] ? mem[raddr] : '0;
	end

	assign pair = adcm9_pkg::xchg_pair(cmd.xchg_step);
	assign ia   = pair[7:4];
	assign ib   = pair[3:0];
	assign va   = v_q[ia];
	assign vb   = v_q[ib];

	always_ff @(posedge clk) begin
		if (cmd.ld_en) v_q[cmd.ld_idx] <= rd_q;
		else if (cmd.xchg_en && va > vb) begin
			v_q[ia] <= vb;
			v_q[ib] <= va;
		end
		if (cmd.med_cap) med_q[cmd.med_sel] <= v_q[4];
	end

	assign diff = $signed({1'b0, cal30_q}) - $signed({1'b0, med_q[1]});
	assign den  = $signed({1'b0, cal30_q}) - $signed({1'b0, cal110_q});

	always_ff @(posedge clk) begin
		if (cmd.prod_en) begin
			num_q  <= adcm9_pkg::TEMP_W'(diff) * $signed(23'sd800);
			den_q  <= den;
			vnum_q <= adcm9_pkg::VDD_W'(vref_q) * adcm9_pkg::VDD_W'(330);
		end
	end

	assign num_mag = num_q[adcm9_pkg::TEMP_W-1] ? adcm9_pkg::TEMP_W'(-num_q)
		: adcm9_pkg::TEMP_W'(num_q);
	assign den_mag = den_q[adcm9_pkg::DVS_W-1] ? adcm9_pkg::DVS_W'(-den_q)
		: adcm9_pkg::DVS_W'(den_q);

	adcm9_div u_tdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (num_mag[adcm9_pkg::DVD_W-1:0]),
		.divisor  (den_mag),
		.done     (tdone),
		.quotient (tquo)
	);

	adcm9_div u_vdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (adcm9_pkg::DVD_W'(vnum_q)),
		.divisor  ({1'b0, med_q[2]}),
		.done     (vdone),
		.quotient (vquo)
	);

	// truncation toward zero: divide magnitudes, then restore the sign
	assign tsigned = (num_q[adcm9_pkg::TEMP_W-1] ^ den_q[adcm9_pkg::DVS_W-1]) ?
		-$signed({1'b0, tquo}) : $signed({1'b0, tquo});

	assign sts.div_done = tdone && vdone;
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			median <= med_q[0];
			if (den_q == '0) temperature_tenths <= '0;
			else temperature_tenths <= tsigned + $signed(23'sd300);
			vdd_hundredths  <= (med_q[2] == '0) ? '0 : vquo[adcm9_pkg::VDD_W-1:0];
			divide_fault[0] <= (den_q == '0);
			divide_fault[1] <= (med_q[2] == '0);
		end
	end

	assign out_valid = out_valid_q;
endmodule

// ----- tb/adc_median9_calibrated_readout_test.sv -----
`timescale 1ns / 100ps

module adc_median9_calibrated_readout_test;
	import adcm9_pkg::*;

	typedef struct {
		logic [SMP_W-1:0]         med;
		logic signed [TEMP_W-1:0] temp;
		logic [VDD_W-1:0]         vdd;
		logic [1:0]               fault;
	} readout_t;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic                        op;
	logic [SMP_W-1:0]            sample;
	logic [CH_W-1:0]             channel;
	logic                        out_valid;
	logic                        out_ready;
	logic [SMP_W-1:0]            median;
	logic signed [TEMP_W-1:0]    temperature_tenths;
	logic [VDD_W-1:0]            vdd_hundredths;
	logic [1:0]                  divide_fault;
	logic                        cfg_we;
	logic [1:0]                  cfg_index;
	logic [SMP_W-1:0]            cfg_wdata;

	// local copy of block state
	logic [SMP_W-1:0] store_copy [SLOTS];
	int unsigned      slot_copy;
	logic [SMP_W-1:0] cal30, cal110, vref;

	readout_t   readout_queue[$];
	int         mismatches;
	int         reads_seen;
	int         items_sent;
	int         burst_left;
	int         stall_phase;

	adc_median9_calibrated_readout dut (.*);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	function automatic logic [SMP_W-1:0] channel_median(int unsigned ch);
		logic [SMP_W-1:0] v [9];
		logic [SMP_W-1:0] t;
		int pa [19] = '{1,4,7,0,3,6,1,4,7,0,5,4,3,1,2,4,4,6,4};
		int pb [19] = '{2,5,8,1,4,7,2,5,8,3,8,7,6,4,5,7,2,4,2};
		int unsigned c;
		c = ch % CHANNELS;
		for (int i = 0; i < 9; i++)
			v[i] = store_copy[(c + i * CHANNELS) % SLOTS];
		for (int s = 0; s < 19; s++) begin
			if (v[pa[s]] > v[pb[s]]) begin
				t = v[pa[s]];
				v[pa[s]] = v[pb[s]];
				v[pb[s]] = t;
			end
		end
		return v[4];
	endfunction

	function automatic readout_t predict_readout(logic [CH_W-1:0] ch);
		readout_t r;
		int m2, m3, den, num;
		r.med = channel_median(ch);
		m2 = channel_median(2);
		m3 = channel_median(3);
		r.fault = 2'b00;
		r.temp = '0;
		r.vdd = '0;
		den = int'(cal30) - int'(cal110);
		if (den == 0)
			r.fault[0] = 1'b1;
		else begin
			num = (int'(cal30) - m2) * 800;
			r.temp = TEMP_W'(num / den + 300);
		end
		if (m3 == 0)
			r.fault[1] = 1'b1;
		else
			r.vdd = VDD_W'((int'(vref) * 330) / m3);
		return r;
	endfunction

	task automatic send_item(logic o, logic [SMP_W-1:0] s, logic [CH_W-1:0] ch);
		// bursty sender: sometimes a random gap between bursts
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		op <= o;
		sample <= s;
		channel <= ch;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (o == OP_STORE) begin
			store_copy[slot_copy] = s;
			slot_copy = (slot_copy + 1) % SLOTS;
		end else
			readout_queue.push_back(predict_readout(ch));
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (readout_queue.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_cal(logic [1:0] idx, logic [SMP_W-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CAL30:  cal30 = val;
			REG_CAL110: cal110 = val;
			REG_VREF:   vref = val;
			default: ;
		endcase
	endtask

	task automatic fill_store(logic [SMP_W-1:0] val);
		for (int i = 0; i < SLOTS; i++)
			send_item(OP_STORE, val, CH_W'($urandom));
	endtask

	task automatic test_zero_store();
		// store still at reset: zero reference median
		for (int c = 0; c < CHANNELS; c++)
			send_item(OP_READ, SMP_W'($urandom), CH_W'(c));
	endtask

	task automatic test_extremes();
		fill_store('1);
		send_item(OP_READ, '0, 2'd3);
		for (int i = 0; i < 7; i++)
			send_item(OP_STORE, (i % 2) ? '1 : '0, 2'd0);
		send_item(OP_READ, '1, 2'd0);
		send_item(OP_READ, '0, 2'd2);
	endtask

	task automatic test_cal_corners();
		write_cal(REG_CAL30, 12'd0);
		write_cal(REG_CAL110, 12'd4095);
		write_cal(REG_VREF, 12'd4095);
		fill_store(12'd1);
		send_item(OP_READ, '0, 2'd3);
		write_cal(REG_CAL30, 12'd4095);
		write_cal(REG_CAL110, 12'd0);
		send_item(OP_READ, '0, 2'd2);
		// equal calibration points: zero divisor
		write_cal(REG_CAL110, 12'd4095);
		write_cal(REG_VREF, 12'd0);
		send_item(OP_READ, '0, 2'd1);
	endtask

	task automatic test_random(int count);
		int n;
		logic [1:0] idx;
		n = 0;
		while (n < count) begin
			if (n % 500 == 499) begin
				idx = 2'($urandom_range(0, 3));
				write_cal(idx, SMP_W'($urandom));
			end
			// mostly stores, sometimes clustered values so medians vary
			if ($urandom_range(0, 9) < 8)
				send_item(OP_STORE, ($urandom_range(0, 3) == 0) ?
					SMP_W'($urandom_range(0, 3)) : SMP_W'($urandom), CH_W'($urandom));
			else
				send_item(OP_READ, SMP_W'($urandom), CH_W'($urandom));
			n++;
		end
	endtask

	// receiver stalls on a rotating pattern
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		if ((stall_phase / 64) % 3 == 0)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		readout_t e;
		if (arst_n && out_valid && out_ready) begin
			reads_seen++;
			if (readout_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: median %0d", median);
			end else begin
				e = readout_queue.pop_front();
				if (e.med !== median || e.temp !== temperature_tenths ||
						e.vdd !== vdd_hundredths || e.fault !== divide_fault) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp med %0d temp %0d vdd %0d flt %0d, got %0d %0d %0d %0d",
							e.med, e.temp, e.vdd, e.fault,
							median, temperature_tenths, vdd_hundredths, divide_fault);
				end
			end
		end
	end

	initial begin
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_STORE;
		sample = '0;
		channel = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		stall_phase = 0;
		mismatches = 0;
		reads_seen = 0;
		items_sent = 0;
		burst_left = 0;
		slot_copy = 0;
		cal30 = 12'd1700;
		cal110 = 12'd1300;
		vref = 12'd1520;
		for (int i = 0; i < SLOTS; i++)
			store_copy[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_store();
		test_extremes();
		test_cal_corners();
		write_cal(REG_CAL30, 12'd1700);
		write_cal(REG_CAL110, 12'd1300);
		write_cal(REG_VREF, 12'd1520);
		test_random(2000);
		drain();

		$display("sent %0d transactions, checked %0d readouts", items_sent, reads_seen);
		if (mismatches == 0 && readout_queue.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
